FILE: hw/rtl/sidv_pkg.sv
package sidv_pkg;

	localparam int UriLenW = 12;
	localparam int DomLenW = 8;
	localparam int CodeW = 4;

	localparam logic [CodeW-1:0] ERR_OK          = 4'd0;
	localparam logic [CodeW-1:0] ERR_EMPTY       = 4'd1;
	localparam logic [CodeW-1:0] ERR_TOO_LONG    = 4'd2;
	localparam logic [CodeW-1:0] ERR_HASH        = 4'd3;
	localparam logic [CodeW-1:0] ERR_QUERY       = 4'd4;
	localparam logic [CodeW-1:0] ERR_NON_ASCII   = 4'd5;
	localparam logic [CodeW-1:0] ERR_PREFIX      = 4'd6;
	localparam logic [CodeW-1:0] ERR_TRAIL_SLASH = 4'd7;
	localparam logic [CodeW-1:0] ERR_DOM_EMPTY   = 4'd8;
	localparam logic [CodeW-1:0] ERR_DOM_LONG    = 4'd9;
	localparam logic [CodeW-1:0] ERR_DOM_CHAR    = 4'd10;
	localparam logic [CodeW-1:0] ERR_SEG_EMPTY   = 4'd11;
	localparam logic [CodeW-1:0] ERR_SEG_DOT     = 4'd12;
	localparam logic [CodeW-1:0] ERR_PATH_CHAR   = 4'd13;

	localparam logic REG_MAX_URI = 1'b0;
	localparam logic REG_MAX_DOM = 1'b1;

	localparam logic [1:0] PH_PREFIX = 2'd0;
	localparam logic [1:0] PH_DOMAIN = 2'd1;
	localparam logic [1:0] PH_PATH   = 2'd2;

	localparam logic [1:0] PE_NONE  = 2'd0;
	localparam logic [1:0] PE_EMPTY = 2'd1;
	localparam logic [1:0] PE_DOT   = 2'd2;
	localparam logic [1:0] PE_CHAR  = 2'd3;

	localparam logic [UriLenW-1:0] MAX_URI_RESET = 12'd2048;
	localparam logic [DomLenW-1:0] MAX_DOM_RESET = 8'd255;
	localparam logic [3:0] SCHEME_LEN = 4'd9;

	function automatic logic [7:0] scheme_char(input logic [3:0] pos);
		logic [7:0] ch;
		unique case (pos)
			4'd0: ch = "s";
			4'd1: ch = "p";
			4'd2: ch = "i";
			4'd3: ch = "f";
			4'd4: ch = "f";
			4'd5: ch = "e";
			4'd6: ch = ":";
			4'd7: ch = "/";
			4'd8: ch = "/";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_lower_digit_mark(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
			c == "." || c == "-" || c == "_";
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

endpackage

FILE: hw/rtl/spiffe_id_validator.sv
// Channel   Direction  Handshake           Payload
// cfg       in         cfg_wr_en           cfg_addr, cfg_wdata
// in        in         in_valid/in_ready   char_in, last, empty_string
// out       out        out_valid/out_ready error_code, domain_length, path_length
//
// One request is taken every cycle unless a final request stalls. The result for a URI
// passes the input register, then the result register, once its final request is accepted.
// A final request waits in the input register while the result register holds an
// unread result, and the input stalls behind it; other requests never wait there.
// Reset loads the limit registers with 2048 and 255 and clears all checker state.
module spiffe_id_validator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_addr,
	input  logic [sidv_pkg::UriLenW-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     char_in,
	input  logic                           last,
	input  logic                           empty_string,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sidv_pkg::CodeW-1:0]     error_code,
	output logic [sidv_pkg::DomLenW-1:0]   domain_length,
	output logic [sidv_pkg::UriLenW-1:0]   path_length
);
	import sidv_pkg::*;

	logic [UriLenW-1:0] max_uri_q;
	logic [DomLenW-1:0] max_dom_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       empty_s1;

	logic [UriLenW:0]   byte_cnt_q, n_byte_cnt;
	logic [1:0]         phase_q, n_phase;
	logic               prefix_ok_q, n_prefix_ok;
	logic               saw_hash_q, n_saw_hash;
	logic               saw_query_q, n_saw_query;
	logic               saw_nonascii_q, n_saw_nonascii;
	logic [DomLenW:0]   dom_cnt_q, n_dom_cnt;
	logic               dom_bad_q, n_dom_bad;
	logic [1:0]         seg_cnt_q, n_seg_cnt;
	logic               seg_dots_q, n_seg_dots;
	logic [1:0]         path_err_q, n_path_err;
	logic [UriLenW-1:0] path_cnt_q, n_path_cnt;
	logic               prev_slash_q, n_prev_slash;

	logic               end_s1;
	logic               go_s1;
	logic [7:0]         low_char;
	logic [1:0]         fin_path_err;
	logic [CodeW-1:0]   code;

	logic               out_valid_q;
	logic [CodeW-1:0]   code_q;
	logic [DomLenW-1:0] dom_len_q;
	logic [UriLenW-1:0] path_len_q;

	assign end_s1 = valid_s1 && (last_s1 || empty_s1);
	assign go_s1 = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;
	assign low_char = is_upper(char_s1) ? char_s1 + 8'd32 : char_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_uri_q <= MAX_URI_RESET;
			max_dom_q <= MAX_DOM_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_MAX_URI: max_uri_q <= cfg_wdata;
				REG_MAX_DOM: max_dom_q <= cfg_wdata[DomLenW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			last_s1 <= last;
			empty_s1 <= empty_string;
		end
	end

	// The next state includes the byte held in the input register, so the
	// verdict for a final byte sees its own effect.
	always_comb begin
		n_byte_cnt = byte_cnt_q;
		n_phase = phase_q;
		n_prefix_ok = prefix_ok_q;
		n_saw_hash = saw_hash_q;
		n_saw_query = saw_query_q;
		n_saw_nonascii = saw_nonascii_q;
		n_dom_cnt = dom_cnt_q;
		n_dom_bad = dom_bad_q;
		n_seg_cnt = seg_cnt_q;
		n_seg_dots = seg_dots_q;
		n_path_err = path_err_q;
		n_path_cnt = path_cnt_q;
		n_prev_slash = prev_slash_q;
		if (valid_s1 && !empty_s1) begin
			if (byte_cnt_q < (UriLenW+1)'(1 << UriLenW)) begin
				n_byte_cnt = byte_cnt_q + 1'b1;
			end
			if (char_s1 == "#") begin
				n_saw_hash = 1'b1;
			end
			if (char_s1 == "?") begin
				n_saw_query = 1'b1;
			end
			if (char_s1[7]) begin
				n_saw_nonascii = 1'b1;
			end
			n_prev_slash = (char_s1 == "/");
			unique case (phase_q)
				PH_PREFIX: begin
					if (byte_cnt_q < (UriLenW+1)'(SCHEME_LEN) &&
						low_char != scheme_char(byte_cnt_q[3:0])) begin
						n_prefix_ok = 1'b0;
					end
					if (byte_cnt_q >= (UriLenW+1)'(SCHEME_LEN - 4'd1)) begin
						n_phase = PH_DOMAIN;
					end
				end
				PH_DOMAIN: begin
					if (char_s1 == "/") begin
						n_phase = PH_PATH;
						n_path_cnt = UriLenW'(1);
					end else begin
						if (dom_cnt_q != '1) begin
							n_dom_cnt = dom_cnt_q + 1'b1;
						end
						if (!is_lower_digit_mark(char_s1)) begin
							n_dom_bad = 1'b1;
						end
					end
				end
				default: begin
					if (path_cnt_q != '1) begin
						n_path_cnt = path_cnt_q + 1'b1;
					end
					if (char_s1 == "/") begin
						if (path_err_q == PE_NONE) begin
							if (seg_cnt_q == 2'd0) begin
								n_path_err = PE_EMPTY;
							end else if (seg_dots_q && seg_cnt_q != 2'd3) begin
								n_path_err = PE_DOT;
							end
						end
						n_seg_cnt = 2'd0;
						n_seg_dots = 1'b1;
					end else begin
						if (seg_cnt_q != 2'd3) begin
							n_seg_cnt = seg_cnt_q + 1'b1;
						end
						if (char_s1 != ".") begin
							n_seg_dots = 1'b0;
						end
						if (path_err_q == PE_NONE && !is_lower_digit_mark(char_s1) &&
							!is_upper(char_s1)) begin
							n_path_err = PE_CHAR;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		fin_path_err = n_path_err;
		if (n_path_err == PE_NONE && n_seg_cnt != 2'd0 && n_seg_dots &&
			n_seg_cnt != 2'd3) begin
			fin_path_err = PE_DOT;
		end
		priority if (n_byte_cnt == '0) begin
			code = ERR_EMPTY;
		end else if (n_byte_cnt > {1'b0, max_uri_q}) begin
			code = ERR_TOO_LONG;
		end else if (n_saw_hash) begin
			code = ERR_HASH;
		end else if (n_saw_query) begin
			code = ERR_QUERY;
		end else if (n_saw_nonascii) begin
			code = ERR_NON_ASCII;
		end else if (!n_prefix_ok || n_phase == PH_PREFIX) begin
			code = ERR_PREFIX;
		end else if (n_prev_slash) begin
			code = ERR_TRAIL_SLASH;
		end else if (n_dom_cnt == '0) begin
			code = ERR_DOM_EMPTY;
		end else if (n_dom_cnt > {1'b0, max_dom_q}) begin
			code = ERR_DOM_LONG;
		end else if (n_dom_bad) begin
			code = ERR_DOM_CHAR;
		end else if (n_phase == PH_PATH && fin_path_err == PE_EMPTY) begin
			code = ERR_SEG_EMPTY;
		end else if (n_phase == PH_PATH && fin_path_err == PE_DOT) begin
			code = ERR_SEG_DOT;
		end else if (n_phase == PH_PATH && fin_path_err == PE_CHAR) begin
			code = ERR_PATH_CHAR;
		end else begin
			code = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			phase_q <= PH_PREFIX;
			prefix_ok_q <= 1'b1;
			saw_hash_q <= 1'b0;
			saw_query_q <= 1'b0;
			saw_nonascii_q <= 1'b0;
			dom_cnt_q <= '0;
			dom_bad_q <= 1'b0;
			seg_cnt_q <= 2'd0;
			seg_dots_q <= 1'b1;
			path_err_q <= PE_NONE;
			path_cnt_q <= '0;
			prev_slash_q <= 1'b0;
		end else if (go_s1) begin
			if (end_s1) begin
				byte_cnt_q <= '0;
				phase_q <= PH_PREFIX;
				prefix_ok_q <= 1'b1;
				saw_hash_q <= 1'b0;
				saw_query_q <= 1'b0;
				saw_nonascii_q <= 1'b0;
				dom_cnt_q <= '0;
				dom_bad_q <= 1'b0;
				seg_cnt_q <= 2'd0;
				seg_dots_q <= 1'b1;
				path_err_q <= PE_NONE;
				path_cnt_q <= '0;
				prev_slash_q <= 1'b0;
			end else begin
				byte_cnt_q <= n_byte_cnt;
				phase_q <= n_phase;
				prefix_ok_q <= n_prefix_ok;
				saw_hash_q <= n_saw_hash;
				saw_query_q <= n_saw_query;
				saw_nonascii_q <= n_saw_nonascii;
				dom_cnt_q <= n_dom_cnt;
				dom_bad_q <= n_dom_bad;
				seg_cnt_q <= n_seg_cnt;
				seg_dots_q <= n_seg_dots;
				path_err_q <= n_path_err;
				path_cnt_q <= n_path_cnt;
				prev_slash_q <= n_prev_slash;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && end_s1) begin
			code_q <= code;
			dom_len_q <= (code == ERR_OK) ? n_dom_cnt[DomLenW-1:0] : '0;
			path_len_q <= (code == ERR_OK) ? n_path_cnt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign error_code = code_q;
	assign domain_length = dom_len_q;
	assign path_length = path_len_q;

	a_body_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !end_s1 |-> go_s1)
		else $error("non-final byte stalled in the input register");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && end_s1 |=> byte_cnt_q == '0 && phase_q == PH_PREFIX &&
			path_err_q == PE_NONE)
		else $error("checker state not cleared after a final request");

	a_lengths_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> domain_length == '0 && path_length == '0)
		else $error("lengths reported with an error code");

	a_ok_has_domain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_OK |-> domain_length != '0)
		else $error("accepted URI with an empty trust domain");

endmodule
